// ===== rtl/lbs_pkg.sv =====
package lbs_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_BLINK = 2'd1,
        OP_STOP  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2,
        PH_RSVD = 2'd3
    } phase_t;

    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 16;

    // one input beat, unpacked
    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  blink_count;
        logic [7:0]  brightness;
        logic [15:0] on_time_ms;
        logic [15:0] off_time_ms;
        logic        hold_last;
    } lbs_item_t;

    // stored blink command, table defaults already applied
    typedef struct packed {
        logic [7:0]  count;
        logic [7:0]  level;
        logic [15:0] on_len;
        logic [15:0] off_len;
        logic        hold;
    } lbs_cmd_t;

    typedef struct packed {
        logic [7:0] led_level;
        phase_t     phase;
        logic       command_waiting;
        logic       stopped;
    } lbs_result_t;

    function automatic logic [15:0] default_on_len(input logic [7:0] count);
        logic [15:0] len;
        case (count)
            8'd1:    len = 16'd400;
            8'd2:    len = 16'd100;
            8'd3:    len = 16'd67;
            default: len = 16'd50;
        endcase
        return len;
    endfunction

    function automatic logic [15:0] default_off_len(input logic [7:0] count);
        logic [15:0] len;
        case (count)
            8'd1:    len = 16'd400;
            8'd2:    len = 16'd300;
            8'd3:    len = 16'd200;
            default: len = 16'd150;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/lbs_core.sv =====
module lbs_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  lbs_pkg::lbs_item_t   item,
    output lbs_pkg::lbs_result_t result
);

    lbs_pkg::phase_t   phase_reg, phase_next;
    logic              pending_valid_reg, pending_valid_next;
    lbs_pkg::lbs_cmd_t pending_cmd_reg, pending_cmd_next;
    lbs_pkg::lbs_cmd_t active_cmd_reg, active_cmd_next;
    logic [7:0]        blinks_done_reg, blinks_done_next;
    logic [15:0]       elapsed_reg, elapsed_next;
    logic [7:0]        level_reg, level_next;
    logic              stop_req_reg, stop_req_next;
    logic              stop_done_reg, stop_done_next;

    logic [15:0] elapsed_inc;
    logic [7:0]  last_idx;
    logic        on_last_blink;

    assign elapsed_inc   = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign last_idx      = active_cmd_reg.count - 8'd1;
    assign on_last_blink = (active_cmd_reg.count != 8'd0) && (blinks_done_reg == last_idx);

    always_comb begin
        phase_next         = phase_reg;
        pending_valid_next = pending_valid_reg;
        pending_cmd_next   = pending_cmd_reg;
        active_cmd_next    = active_cmd_reg;
        blinks_done_next   = blinks_done_reg;
        elapsed_next       = elapsed_reg;
        level_next         = level_reg;
        stop_req_next      = stop_req_reg;
        stop_done_next     = stop_done_reg;

        if (!stop_done_reg) begin
            case (item.opcode)
                lbs_pkg::OP_TICK: begin
                    if (phase_reg == lbs_pkg::PH_IDLE) begin
                        if (pending_valid_reg) begin
                            active_cmd_next    = pending_cmd_reg;
                            pending_valid_next = 1'b0;
                            blinks_done_next   = 8'd0;
                            phase_next         = lbs_pkg::PH_ON;
                            level_next         = pending_cmd_reg.level;
                            elapsed_next       = 16'd0;
                        end else if (stop_req_reg) begin
                            stop_done_next = 1'b1;
                        end
                    end else begin
                        elapsed_next = elapsed_inc;
                        if (phase_reg == lbs_pkg::PH_ON) begin
                            if (elapsed_inc >= active_cmd_reg.on_len) begin
                                if (active_cmd_reg.hold && on_last_blink) begin
                                    // final blink stays lit
                                    phase_next = lbs_pkg::PH_IDLE;
                                end else begin
                                    phase_next   = lbs_pkg::PH_OFF;
                                    level_next   = 8'd0;
                                    elapsed_next = 16'd0;
                                end
                            end
                        end else begin
                            if (elapsed_inc >= active_cmd_reg.off_len) begin
                                if (active_cmd_reg.count != 8'd0 &&
                                    blinks_done_reg < last_idx) begin
                                    blinks_done_next = blinks_done_reg + 8'd1;
                                    phase_next       = lbs_pkg::PH_ON;
                                    level_next       = active_cmd_reg.level;
                                    elapsed_next     = 16'd0;
                                end else begin
                                    phase_next = lbs_pkg::PH_IDLE;
                                end
                            end
                        end
                    end
                end
                lbs_pkg::OP_BLINK: begin
                    pending_cmd_next.count   = item.blink_count;
                    pending_cmd_next.level   = item.brightness;
                    pending_cmd_next.on_len  = (item.on_time_ms == 16'd0) ?
                        lbs_pkg::default_on_len(item.blink_count) : item.on_time_ms;
                    pending_cmd_next.off_len = (item.off_time_ms == 16'd0) ?
                        lbs_pkg::default_off_len(item.blink_count) : item.off_time_ms;
                    pending_cmd_next.hold    = item.hold_last;
                    pending_valid_next       = 1'b1;
                end
                lbs_pkg::OP_STOP: begin
                    stop_req_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= lbs_pkg::PH_IDLE;
            pending_valid_reg <= 1'b0;
            pending_cmd_reg   <= '0;
            active_cmd_reg    <= '0;
            blinks_done_reg   <= 8'd0;
            elapsed_reg       <= 16'd0;
            level_reg         <= 8'd0;
            stop_req_reg      <= 1'b0;
            stop_done_reg     <= 1'b0;
        end else if (step_en) begin
            phase_reg         <= phase_next;
            pending_valid_reg <= pending_valid_next;
            pending_cmd_reg   <= pending_cmd_next;
            active_cmd_reg    <= active_cmd_next;
            blinks_done_reg   <= blinks_done_next;
            elapsed_reg       <= elapsed_next;
            level_reg         <= level_next;
            stop_req_reg      <= stop_req_next;
            stop_done_reg     <= stop_done_next;
        end
    end

    // view of the state after this beat
    assign result.led_level       = level_next;
    assign result.phase           = phase_next;
    assign result.command_waiting = pending_valid_next;
    assign result.stopped         = stop_done_next;

    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_done_reg |=> stop_done_reg)
        else $error("stopped flag dropped");

    a_stop_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        stop_done_reg |-> (phase_reg == lbs_pkg::PH_IDLE) && !pending_valid_reg)
        else $error("stopped while busy or with a command pending");

    a_on_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == lbs_pkg::PH_ON) |-> (level_reg == active_cmd_reg.level))
        else $error("on phase level differs from active command");

    a_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == lbs_pkg::PH_OFF) |-> (level_reg == 8'd0))
        else $error("led lit during off phase");

    a_take_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && item.opcode == lbs_pkg::OP_TICK && !stop_done_reg &&
         phase_reg == lbs_pkg::PH_IDLE && pending_valid_reg)
        |=> (!pending_valid_reg && phase_reg == lbs_pkg::PH_ON))
        else $error("pending command not taken up on idle tick");

endmodule

// ===== rtl/led_blink_sequencer_unit.sv =====
// path: an accepted beat is held in the input register, and its result is loaded
// into the output register when that register is free
// throughput: one beat per cycle while m_axis_tready is high; the state update is
// a single pass through the step logic between the input and output registers
// reset: aresetn low at a rising edge clears control state (idle, no cmd, not stopped)
module led_blink_sequencer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // blink_count[7:0], brightness[15:8], on_time_ms[31:16], off_time_ms[47:32],
    // hold_last[48], zero pad
    input  logic [lbs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // opcode[1:0]
    input  logic [lbs_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // led_level[7:0], phase[9:8], command_waiting[10], stopped[11], zero pad
    output logic [lbs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    logic                  in_valid_reg;
    lbs_pkg::lbs_item_t    in_item_reg;
    logic                  out_valid_reg;
    lbs_pkg::lbs_result_t  out_result_reg;
    lbs_pkg::lbs_result_t  step_result;
    lbs_pkg::lbs_item_t    s_item;
    logic                  advance;

    assign s_item.opcode      = lbs_pkg::opcode_t'(s_axis_tuser[1:0]);
    assign s_item.blink_count = s_axis_tdata[7:0];
    assign s_item.brightness  = s_axis_tdata[15:8];
    assign s_item.on_time_ms  = s_axis_tdata[31:16];
    assign s_item.off_time_ms = s_axis_tdata[47:32];
    assign s_item.hold_last   = s_axis_tdata[48];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    lbs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_result_reg.stopped, out_result_reg.command_waiting,
                            out_result_reg.phase, out_result_reg.led_level};

endmodule
